// ----- rtl/hsv_to_rgb_converter_defines.svh -----
// assertion macros used by the channel select module
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// checked only while out of reset
`define HSV2RGB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define HSV2RGB_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int HUE_W      = 32;
    localparam int CH_IN_W    = 18;
    localparam int CH_OUT_W   = 17;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 56;

    // hue sector, one sixth of a turn each
    typedef enum logic [2:0] {
        SEC_RED_YELLOW,
        SEC_YELLOW_GREEN,
        SEC_GREEN_CYAN,
        SEC_CYAN_BLUE,
        SEC_BLUE_MAGENTA,
        SEC_MAGENTA_RED
    } t_sector;

endpackage

// ----- rtl/hsv_to_rgb_converter.sv -----
// hsv to rgb color converter: each input transfer carries hue (turns, wraps,
// only its fraction bits count), saturation and brightness (both clamped to
// 0..1) and yields exactly one output transfer with red, green and blue, each
// 0..1.0 in the same fixed point (1.0 = 2**FRAC_BITS). one transfer per clock
// while the output is not stalled, through the four register stages:
// clamp and sector split, first products
// (f*s, (1-f)*s, v*(1-s)), second products (q and t), and the channel select
// into the output register. ready runs back through the stages, so a stalled
// output holds its pipeline without losing or repeating items. no state is
// kept between items.
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // hue[31:0], saturation[49:32], brightness[67:50], zero pad[71:68]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // red[16:0], green[33:17], blue[50:34], zero pad[55:51]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int UW = FRAC_BITS + 1;

    // stage 1 -> 2
    logic                 c_valid;
    logic                 c_ready;
    logic [UW-1:0]        c_s;
    logic [UW-1:0]        c_oms;
    logic [FRAC_BITS-1:0] c_f;
    logic [UW-1:0]        c_omf;
    logic [UW-1:0]        c_v;
    t_sector              c_sector;

    // stage 2 -> 3
    logic                 k_valid;
    logic                 k_ready;
    logic [UW-1:0]        k_kq;
    logic [UW-1:0]        k_kt;
    logic [UW-1:0]        k_p;
    logic [UW-1:0]        k_v;
    t_sector              k_sector;

    // stage 3 -> 4
    logic                 m_valid;
    logic                 m_ready;
    logic [UW-1:0]        m_v;
    logic [UW-1:0]        m_p;
    logic [UW-1:0]        m_q;
    logic [UW-1:0]        m_t;
    t_sector              m_sector;

    logic [CH_OUT_W-1:0]  out_red;
    logic [CH_OUT_W-1:0]  out_green;
    logic [CH_OUT_W-1:0]  out_blue;

    // clamp, hue times six, one-minus terms
    hsv2rgb_clamp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_clamp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_hue        (s_axis_tdata[HUE_W-1:0]),
        .i_saturation (s_axis_tdata[HUE_W+CH_IN_W-1:HUE_W]),
        .i_brightness (s_axis_tdata[HUE_W+2*CH_IN_W-1:HUE_W+CH_IN_W]),
        .o_valid      (c_valid),
        .i_ready      (c_ready),
        .o_s          (c_s),
        .o_oms        (c_oms),
        .o_f          (c_f),
        .o_omf        (c_omf),
        .o_v          (c_v),
        .o_sector     (c_sector)
    );

    // p and the q, t multipliers' second operands
    hsv2rgb_coef #(
        .FRAC_BITS (FRAC_BITS)
    ) u_coef (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_valid),
        .o_ready  (c_ready),
        .i_s      (c_s),
        .i_oms    (c_oms),
        .i_f      (c_f),
        .i_omf    (c_omf),
        .i_v      (c_v),
        .i_sector (c_sector),
        .o_valid  (k_valid),
        .i_ready  (k_ready),
        .o_kq     (k_kq),
        .o_kt     (k_kt),
        .o_p      (k_p),
        .o_v      (k_v),
        .o_sector (k_sector)
    );

    // q = v*(1-fs), t = v*(1-(1-f)s)
    hsv2rgb_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (k_valid),
        .o_ready  (k_ready),
        .i_kq     (k_kq),
        .i_kt     (k_kt),
        .i_p      (k_p),
        .i_v      (k_v),
        .i_sector (k_sector),
        .o_valid  (m_valid),
        .i_ready  (m_ready),
        .o_v      (m_v),
        .o_p      (m_p),
        .o_q      (m_q),
        .o_t      (m_t),
        .o_sector (m_sector)
    );

    // per-sector channel routing and output register
    hsv2rgb_sel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (m_valid),
        .o_ready  (m_ready),
        .i_v      (m_v),
        .i_p      (m_p),
        .i_q      (m_q),
        .i_t      (m_t),
        .i_sector (m_sector),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_red    (out_red),
        .o_green  (out_green),
        .o_blue   (out_blue)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - 3*CH_OUT_W)'(0), out_blue, out_green, out_red};

endmodule

// ----- rtl/hsv2rgb_clamp.sv -----
module hsv2rgb_clamp
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [HUE_W-1:0]      i_hue,
    input  logic [CH_IN_W-1:0]    i_saturation,
    input  logic [CH_IN_W-1:0]    i_brightness,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [FRAC_BITS:0]    o_s,
    output logic [FRAC_BITS:0]    o_oms,
    output logic [FRAC_BITS-1:0]  o_f,
    output logic [FRAC_BITS:0]    o_omf,
    output logic [FRAC_BITS:0]    o_v,
    output t_sector               o_sector
);

    localparam int UW = FRAC_BITS + 1;
    localparam int HW = FRAC_BITS + 3;
    localparam logic [32:0] ONE_WIDE = 33'(1) << FRAC_BITS;
    localparam logic [UW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // negative clamps to zero, above one clamps to one
    function automatic logic [UW-1:0] clamp_unit(input logic [CH_IN_W-1:0] raw);
        logic [32:0] mag;
        begin
            mag = 33'(raw[CH_IN_W-2:0]);
            if (raw[CH_IN_W-1]) begin
                clamp_unit = '0;
            end else if (mag > ONE_WIDE) begin
                clamp_unit = UW'(ONE_WIDE);
            end else begin
                clamp_unit = UW'(mag);
            end
        end
    endfunction

    logic [HW-1:0] h6;
    logic [UW-1:0] s_c;
    logic [UW-1:0] v_c;

    logic               r_valid;
    logic [UW-1:0]      r_s;
    logic [UW-1:0]      r_oms;
    logic [FRAC_BITS-1:0] r_f;
    logic [UW-1:0]      r_omf;
    logic [UW-1:0]      r_v;
    t_sector            r_sector;

    assign h6  = HW'(i_hue[FRAC_BITS-1:0]) * HW'(6);
    assign s_c = clamp_unit(i_saturation);
    assign v_c = clamp_unit(i_brightness);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s      <= s_c;
            r_oms    <= ONE - s_c;
            r_f      <= h6[FRAC_BITS-1:0];
            r_omf    <= ONE - UW'(h6[FRAC_BITS-1:0]);
            r_v      <= v_c;
            r_sector <= t_sector'(h6[HW-1:FRAC_BITS]);
        end
    end

    assign o_valid  = r_valid;
    assign o_s      = r_s;
    assign o_oms    = r_oms;
    assign o_f      = r_f;
    assign o_omf    = r_omf;
    assign o_v      = r_v;
    assign o_sector = r_sector;

endmodule

// ----- rtl/hsv2rgb_coef.sv -----
module hsv2rgb_coef
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [FRAC_BITS:0]    i_s,
    input  logic [FRAC_BITS:0]    i_oms,
    input  logic [FRAC_BITS-1:0]  i_f,
    input  logic [FRAC_BITS:0]    i_omf,
    input  logic [FRAC_BITS:0]    i_v,
    input  t_sector               i_sector,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [FRAC_BITS:0]    o_kq,
    output logic [FRAC_BITS:0]    o_kt,
    output logic [FRAC_BITS:0]    o_p,
    output logic [FRAC_BITS:0]    o_v,
    output t_sector               o_sector
);

    localparam int UW = FRAC_BITS + 1;
    localparam int PW = 2 * UW;
    localparam logic [UW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [PW-1:0] prod_fs;
    logic [PW-1:0] prod_gs;
    logic [PW-1:0] prod_p;

    logic          r_valid;
    logic [UW-1:0] r_kq;
    logic [UW-1:0] r_kt;
    logic [UW-1:0] r_p;
    logic [UW-1:0] r_v;
    t_sector       r_sector;

    // f*s, (1-f)*s, v*(1-s)
    assign prod_fs = PW'(i_f) * PW'(i_s);
    assign prod_gs = PW'(i_omf) * PW'(i_s);
    assign prod_p  = PW'(i_v) * PW'(i_oms);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_kq     <= ONE - prod_fs[FRAC_BITS+UW-1:FRAC_BITS];
            r_kt     <= ONE - prod_gs[FRAC_BITS+UW-1:FRAC_BITS];
            r_p      <= prod_p[FRAC_BITS+UW-1:FRAC_BITS];
            r_v      <= i_v;
            r_sector <= i_sector;
        end
    end

    assign o_valid  = r_valid;
    assign o_kq     = r_kq;
    assign o_kt     = r_kt;
    assign o_p      = r_p;
    assign o_v      = r_v;
    assign o_sector = r_sector;

endmodule

// ----- rtl/hsv2rgb_scale.sv -----
module hsv2rgb_scale
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [FRAC_BITS:0]    i_kq,
    input  logic [FRAC_BITS:0]    i_kt,
    input  logic [FRAC_BITS:0]    i_p,
    input  logic [FRAC_BITS:0]    i_v,
    input  t_sector               i_sector,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [FRAC_BITS:0]    o_v,
    output logic [FRAC_BITS:0]    o_p,
    output logic [FRAC_BITS:0]    o_q,
    output logic [FRAC_BITS:0]    o_t,
    output t_sector               o_sector
);

    localparam int UW = FRAC_BITS + 1;
    localparam int PW = 2 * UW;

    logic [PW-1:0] prod_q;
    logic [PW-1:0] prod_t;

    logic          r_valid;
    logic [UW-1:0] r_v;
    logic [UW-1:0] r_p;
    logic [UW-1:0] r_q;
    logic [UW-1:0] r_t;
    t_sector       r_sector;

    assign prod_q = PW'(i_v) * PW'(i_kq);
    assign prod_t = PW'(i_v) * PW'(i_kt);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_v      <= i_v;
            r_p      <= i_p;
            r_q      <= prod_q[FRAC_BITS+UW-1:FRAC_BITS];
            r_t      <= prod_t[FRAC_BITS+UW-1:FRAC_BITS];
            r_sector <= i_sector;
        end
    end

    assign o_valid  = r_valid;
    assign o_v      = r_v;
    assign o_p      = r_p;
    assign o_q      = r_q;
    assign o_t      = r_t;
    assign o_sector = r_sector;

endmodule

// ----- rtl/hsv2rgb_sel.sv -----
module hsv2rgb_sel
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [FRAC_BITS:0]    i_v,
    input  logic [FRAC_BITS:0]    i_p,
    input  logic [FRAC_BITS:0]    i_q,
    input  logic [FRAC_BITS:0]    i_t,
    input  t_sector               i_sector,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [CH_OUT_W-1:0]   o_red,
    output logic [CH_OUT_W-1:0]   o_green,
    output logic [CH_OUT_W-1:0]   o_blue
);

`include "hsv_to_rgb_converter_defines.svh"

    localparam int UW = FRAC_BITS + 1;

    logic [UW-1:0] n_red;
    logic [UW-1:0] n_green;
    logic [UW-1:0] n_blue;

    logic                r_valid;
    logic [CH_OUT_W-1:0] r_red;
    logic [CH_OUT_W-1:0] r_green;
    logic [CH_OUT_W-1:0] r_blue;

    logic take;
    logic in_gray;
    logic out_black;
    logic out_gray;

    always_comb begin
        case (i_sector)
            SEC_RED_YELLOW: begin
                n_red = i_v; n_green = i_t; n_blue = i_p;
            end
            SEC_YELLOW_GREEN: begin
                n_red = i_q; n_green = i_v; n_blue = i_p;
            end
            SEC_GREEN_CYAN: begin
                n_red = i_p; n_green = i_v; n_blue = i_t;
            end
            SEC_CYAN_BLUE: begin
                n_red = i_p; n_green = i_q; n_blue = i_v;
            end
            SEC_BLUE_MAGENTA: begin
                n_red = i_t; n_green = i_p; n_blue = i_v;
            end
            default: begin
                n_red = i_v; n_green = i_p; n_blue = i_q;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // channels keep their low 17 bits
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_red   <= CH_OUT_W'(n_red);
            r_green <= CH_OUT_W'(n_green);
            r_blue  <= CH_OUT_W'(n_blue);
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    assign take      = i_valid && o_ready;
    assign in_gray   = (i_p == i_v) && (i_q == i_v) && (i_t == i_v);
    assign out_black = (r_red == '0) && (r_green == '0) && (r_blue == '0);
    assign out_gray  = (r_red == r_green) && (r_green == r_blue);

    `HSV2RGB_ASSERT_RST(a_reset_empty, !i_rst_n |=> !r_valid, "output valid after reset")
    `HSV2RGB_ASSERT(a_load_valid, i_valid && o_ready |=> r_valid, "taken item not presented")
    `HSV2RGB_ASSERT(a_black, take && (i_v == '0) |=> out_black, "zero brightness not black")
    `HSV2RGB_ASSERT(a_gray, take && in_gray |=> out_gray, "gray input gave color")

endmodule

// ----- verif/hsv_to_rgb_converter_test.sv -----
module hsv_to_rgb_converter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hsv2rgb_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    // 1.0 in the channel format
    localparam logic [CH_OUT_W-1:0] UNIT = CH_OUT_W'(1) << FB;
    // 1.0 in the saturation and brightness format
    localparam logic [CH_IN_W-1:0] IN_ONE = CH_IN_W'(UNIT);

    // one color as the block reports it
    typedef struct {
        logic [CH_OUT_W-1:0] red;
        logic [CH_OUT_W-1:0] green;
        logic [CH_OUT_W-1:0] blue;
    } t_rgb;

    // ------------------------------------------------------------------
    // scoreboard: turns each accepted hsv transfer into the rgb color it
    // must produce and checks output transfers against them in order
    // ------------------------------------------------------------------
    class rgb_scoreboard;
        t_rgb pending[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        // sign-extend, then clamp to 0..1.0
        function logic [CH_OUT_W-1:0] clamp_unit(logic signed [CH_IN_W-1:0] x);
            int xi;
            xi = int'(x);
            if (xi < 0) return '0;
            if (xi > int'(UNIT)) return UNIT;
            return xi[CH_OUT_W-1:0];
        endfunction

        // fixed-point product, truncated; operands and result stay within 0..1.0
        function logic [CH_OUT_W-1:0] mul_unit(logic [CH_OUT_W-1:0] a,
                                               logic [CH_OUT_W-1:0] b);
            logic [63:0] prod;
            prod = 64'(a) * 64'(b);
            return CH_OUT_W'(prod >> FB);
        endfunction

        function t_rgb hsv_color(logic [HUE_W-1:0] hue, logic [CH_IN_W-1:0] sat,
                                 logic [CH_IN_W-1:0] bri);
            logic [FB-1:0]       h;
            logic [FB-1:0]       f;
            logic [FB+2:0]       h6;
            logic [CH_OUT_W-1:0] s, v, p, q, t;
            logic [CH_OUT_W-1:0] fs, nfs;
            t_sector             sec;
            t_rgb                rgb;
            // hue wraps: only the fraction of a turn matters
            h   = hue[FB-1:0];
            s   = clamp_unit(sat);
            v   = clamp_unit(bri);
            h6  = (FB + 3)'(h * 6);
            sec = t_sector'(h6[FB+2:FB]);
            f   = h6[FB-1:0];
            p   = mul_unit(v, UNIT - s);
            fs  = mul_unit({1'b0, f}, s);
            nfs = mul_unit(UNIT - {1'b0, f}, s);
            q   = mul_unit(v, UNIT - fs);
            t   = mul_unit(v, UNIT - nfs);
            case (sec)
                SEC_RED_YELLOW:   rgb = '{v, t, p};
                SEC_YELLOW_GREEN: rgb = '{q, v, p};
                SEC_GREEN_CYAN:   rgb = '{p, v, t};
                SEC_CYAN_BLUE:    rgb = '{p, q, v};
                SEC_BLUE_MAGENTA: rgb = '{t, p, v};
                default:          rgb = '{v, p, q};
            endcase
            return rgb;
        endfunction

        function void note_input(logic [HUE_W-1:0] hue, logic [CH_IN_W-1:0] sat,
                                 logic [CH_IN_W-1:0] bri);
            pending.push_back(hsv_color(hue, sat, bri));
        endfunction

        function void compare_channel(string name, logic [CH_OUT_W-1:0] want,
                                      logic [CH_OUT_W-1:0] got);
            if (want !== got) begin
                $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            t_rgb seen;
            t_rgb want;
            seen.red   = word[CH_OUT_W-1:0];
            seen.green = word[2*CH_OUT_W-1:CH_OUT_W];
            seen.blue  = word[3*CH_OUT_W-1:2*CH_OUT_W];
            if (pending.size() == 0) begin
                $display("%0t ns: unexpected output transfer, expected none actual %0d %0d %0d",
                         $time, seen.red, seen.green, seen.blue);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_channel("red", want.red, seen.red);
            compare_channel("green", want.green, seen.green);
            compare_channel("blue", want.blue, seen.blue);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // hue, saturation, brightness, zero pad (lowest bits first)
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // red, green, blue, zero pad (lowest bits first)
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // chance in percent of an idle burst, changed every so often
    int unsigned idle_pct = 0;
    // last stretch of the run: no idling on either side
    bit          calm = 1'b0;

    rgb_scoreboard book;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    hsv_to_rgb_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_color(input logic [HUE_W-1:0] hue, input logic [CH_IN_W-1:0] sat,
                              input logic [CH_IN_W-1:0] bri);
        int unsigned           gap;
        logic [IN_TDATA_W-1:0] word;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 8);
        // idle burst: valid held low before the transfer
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        word = '0;
        word[HUE_W-1:0] = hue;
        word[HUE_W+CH_IN_W-1:HUE_W] = sat;
        word[HUE_W+2*CH_IN_W-1:HUE_W+CH_IN_W] = bri;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        book.note_input(hue, sat, bri);
        @(negedge i_clk);
    endtask

    // mostly random full-width hue, sometimes right around a sector boundary
    function automatic logic [HUE_W-1:0] random_hue();
        logic [HUE_W-1:0] hue;
        int               k;
        hue = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, 5);
            hue[FB-1:0] = FB'((k * int'(UNIT) + 5) / 6 + int'($urandom_range(0, 4)) - 2);
        end
        return hue;
    endfunction

    // mostly in range, with clamp cases and raw random bits mixed in
    function automatic logic [CH_IN_W-1:0] random_channel();
        logic [CH_IN_W-1:0] x;
        case ($urandom_range(0, 9))
            0: x = CH_IN_W'($urandom);
            1: begin
                case ($urandom_range(0, 5))
                    0: x = '0;
                    1: x = IN_ONE;
                    2: x = IN_ONE + 18'd1;
                    3: x = '1;
                    4: x = CH_IN_W'(1) << (CH_IN_W - 1);
                    default: x = ~(CH_IN_W'(1) << (CH_IN_W - 1));
                endcase
            end
            default: x = CH_IN_W'($urandom_range(0, UNIT));
        endcase
        return x;
    endfunction

    // ------------------------------------------------------------------
    // sink side: random backpressure in bursts of idle cycles
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 99) < idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // output monitor: every accepted output transfer goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tdata);
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        book = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every sector at full saturation and brightness
        send_color(32'h0000_0000, IN_ONE, IN_ONE);
        send_color(32'h0000_2aab, IN_ONE, IN_ONE);
        send_color(32'h0000_5556, IN_ONE, IN_ONE);
        send_color(32'h0000_8000, IN_ONE, IN_ONE);
        send_color(32'h0000_aaab, IN_ONE, IN_ONE);
        send_color(32'h0000_d556, IN_ONE, IN_ONE);
        // just below a boundary, and the last hue step of a turn
        send_color(32'h0000_2aaa, IN_ONE, IN_ONE);
        send_color(32'h0000_aaaa, 18'd1, 18'd1);
        send_color(32'h0000_ffff, IN_ONE, IN_ONE - 18'd1);
        // hue extremes, including negative hue wrapping around
        send_color(32'h7fff_ffff, IN_ONE + 18'd1, 18'h1ffff);
        send_color(32'h8000_0000, 18'h20000, 18'h3ffff);
        send_color(32'hffff_c000, 18'h08000, IN_ONE);
        send_color(32'hffff_ffff, 18'h1ffff, IN_ONE);
        send_color(32'hfff8_0000, 18'd50000, 18'd0);
        // negative and above-one saturation and brightness clamp
        send_color(32'h0000_ffff, 18'h3ffff, 18'h1ffff);
        send_color(32'h0001_4000, 18'h20000, 18'd40000);
        send_color(32'h0000_1555, 18'h1ffff, 18'h20000);
        // gray with no saturation, then partial and near-full saturation
        send_color(32'h1234_5555, 18'd0, 18'd40000);
        send_color(32'h0000_ea60, 18'd30000, 18'd50000);
        send_color(32'h0000_4e20, IN_ONE - 18'd1, IN_ONE);

        // random part, idling rate changes every 150 transfers
        for (int i = 0; i < 1800; i++) begin
            if (i % 150 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 12;
                    default: idle_pct = 35;
                endcase
            end
            // halfway: hold the source until the pipeline is empty
            if (i == 900) begin
                s_axis_tvalid <= 1'b0;
                do @(negedge i_clk); while (book.pending.size() != 0);
            end
            if (i >= 1600) calm = 1'b1;
            send_color(random_hue(), random_channel(), random_channel());
        end
        s_axis_tvalid <= 1'b0;

        // drain, then keep watching for any stray output transfer
        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (book.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #400us;
        $display("Regression FAIL");
        $finish;
    end

endmodule
